// ===== rtl/core/blc_pkg.sv =====
package blc_pkg;

  localparam int SW  = 16;   // sample width
  localparam int EW  = 48;   // energy accumulator width
  localparam int DVW = 57;   // dividend width of the power division
  localparam int CVW = 32;   // coefficient / error word width
  localparam int RKW = 26;   // reflection coefficient width, range +-2^24
  localparam int OMW = 25;   // (1 - k*k) in Q.24, range 0..2^24
  localparam int PWW = 40;   // error power output width
  localparam int MOPW = 33;  // multiplier operand width

  localparam logic signed [63:0] ACC_LIM = 64'sd1 << 61;
  localparam logic [63:0]        Q48_ONE = 64'd1 << 48;
  localparam logic [63:0]        HALF24  = 64'd1 << 23;
  localparam logic [RKW-1:0]     Q24_ONE = RKW'(1 << 24);

  localparam int PDIV_STEPS = DVW;  // one quotient bit per step
  localparam int RDIV_STEPS = 26;   // 25 quotient bits and one rounding bit

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [5:0] {
    S_LOAD, S_SQR, S_ENA, S_START, S_PDIV, S_PFIN,
    S_CP_RD, S_CP_WR,
    S_STG, S_CR_RD, S_CR_M0, S_CR_M1, S_CR_M2, S_CR_M3,
    S_REFL, S_RDIV, S_RFIN,
    S_PWR0, S_PWR1, S_PWR2, S_PWR3,
    S_CU_RA, S_CU_RB, S_CU_WR, S_NEXT,
    S_EU_R0, S_EU_L0, S_EU_RD, S_EU_M0, S_EU_M1, S_EU_M2,
    S_OUT_RD, S_OUT_LD, S_OUT_WT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // clamp a sum to +-2^61
  function automatic logic signed [63:0] sat_add61(input logic signed [63:0] acc,
                                                   input logic signed [63:0] term);
    logic signed [63:0] s;
    s = acc + term;
    if (s > ACC_LIM) return ACC_LIM;
    if (s < -ACC_LIM) return -ACC_LIM;
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // drop 24 fraction bits, round half away from zero
  function automatic logic signed [63:0] rs24(input logic signed [63:0] v);
    logic signed [63:0] mag;
    if (!v[63]) begin
      return (v + $signed(HALF24)) >>> 24;
    end
    mag = (-v + $signed(HALF24)) >>> 24;
    return -mag;
  endfunction

endpackage

// ===== rtl/core/blc_in_if.sv =====
interface blc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_sample;
  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

// ===== rtl/core/blc_out_if.sv =====
interface blc_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         coef_index;
  logic signed [31:0] coef_value;
  logic [39:0]        error_power;
  logic [1:0]         status;
  logic               last_result;
  modport source(output valid, coef_index, coef_value, error_power, status, last_result,
                 input ready);
  modport sink(input valid, coef_index, coef_value, error_power, status, last_result,
               output ready);
endinterface

// ===== rtl/core/blc_cfg_if.sv =====
interface blc_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] order;
  modport source(output valid, order, input ready);
  modport sink(input valid, order, output ready);
endinterface

// ===== rtl/core/burg_lpc_coefficients_unit.sv =====
// Burg linear prediction unit. Load: each sample item passes load, square and energy
// states. Run over n samples: a power division and a buffer copy, then per stage k a
// correlation pass, a reflection division (skipped where |k| clamps to one or the stage
// energy is zero), power and coefficient updates and, but for the last, an error pass, all
// on one shared multiplier and a bit-serial divider; no input taken until all results leave.
// Reset (rst, synchronous) sets order to 16, clears count and energy; memories not cleared.
module burg_lpc_coefficients_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_ORDER   = 32
) (
  input logic clk,
  input logic rst,
  blc_in_if.sink    in_ch,
  blc_out_if.source out_ch,
  blc_cfg_if.sink   cfg_ch
);
  import blc_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int KW  = $clog2(MAX_ORDER + 1);
  localparam int CAW = $clog2(MAX_ORDER);

  state_t state, state_next;

  // control and datapath registers
  logic [5:0]             order;
  logic [CW-1:0]          count;
  logic [EW-1:0]          energy;
  logic signed [SW-1:0]   sample_r;
  logic                   stored;
  logic                   last_r;
  logic [CW-1:0]          j;
  logic [KW-1:0]          i;
  logic [KW-1:0]          k;
  logic [KW-1:0]          m;
  logic signed [63:0]     num;
  logic signed [63:0]     den;
  logic signed [CVW-1:0]  fv, bv, fn, bn;
  logic signed [RKW-1:0]  rk;
  logic [OMW-1:0]         onem;
  logic [63:0]            plo;
  logic [63:0]            power;
  logic [1:0]             status;
  logic                   sel;
  logic [5:0]             cnt;
  logic [5:0]             o_index;
  logic signed [CVW-1:0]  o_value;
  logic [PWW-1:0]         o_power;
  logic [1:0]             o_status;
  logic                   o_last;

  // shared units
  logic signed [MOPW-1:0] mul_a, mul_b;
  logic signed [63:0]     p;
  div_ctl_t               div_ctl;
  logic [DVW-1:0]         div_dvd;
  logic [63:0]            div_rem, div_dsr;
  logic [63:0]            div_q;

  // memories
  logic                   f_we, b_we, c_we;
  logic [AW-1:0]          f_waddr, b_waddr, f_raddr, b_raddr;
  logic [CVW-1:0]         f_wdata, b_wdata, f_rdata, b_rdata;
  logic [CAW-1:0]         c_waddr, c_raddr;
  logic [CVW-1:0]         c_wdata, c0_rdata, c1_rdata, c_rdata;
  logic                   c_rsel;

  // helpers
  logic                   in_acc, out_acc;
  logic [6:0]             ord_w;
  logic [KW-1:0]          m_c;
  logic                   n_le_m;
  logic                   full;
  logic [CW-1:0]          jp1, len;
  logic [KW-1:0]          ip1;
  logic                   cp_more, cr_more, eu_more, cu_more;
  logic signed [63:0]     a_abs;
  logic                   big_k;
  logic [63:0]            one_m, prod, pw_new;
  logic [OMW-1:0]         onem_c;
  logic [RKW-1:0]         q26, mag, mag_c;
  logic signed [CVW-1:0]  upd;
  logic signed [CVW-1:0]  src;
  logic signed [CVW-1:0]  rk_w;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign in_ch.ready  = (state == S_LOAD);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = (state == S_OUT_WT);
  assign out_ch.coef_index  = o_index;
  assign out_ch.coef_value  = o_value;
  assign out_ch.error_power = o_power;
  assign out_ch.status      = o_status;
  assign out_ch.last_result = o_last;

  // effective order: zero acts as one, clamp at the top
  always_comb begin
    ord_w = {1'b0, order};
    if (ord_w == 7'd0) begin
      m_c = KW'(1);
    end else if (ord_w > 7'(MAX_ORDER)) begin
      m_c = KW'(MAX_ORDER);
    end else begin
      m_c = KW'(ord_w);
    end
  end

  assign n_le_m  = (CW + 1)'(count) <= (CW + 1)'(m_c);
  assign full    = count >= CW'(MAX_SAMPLES);
  assign jp1     = j + CW'(1);
  assign len     = count - CW'(k);
  assign ip1     = i + KW'(1);
  assign cp_more = ((CW + 1)'(jp1) + (CW + 1)'(1)) < (CW + 1)'(count);
  assign cr_more = jp1 < len;
  assign eu_more = ((CW + 1)'(jp1) + (CW + 1)'(1)) < (CW + 1)'(len);
  assign cu_more = ip1 < k;

  assign a_abs = num[63] ? -num : num;
  assign big_k = {a_abs[62:0], 1'b0} >= den;

  // 1 - k*k in Q.24 and the scaled power, wrapping at 64 bits
  assign one_m  = Q48_ONE - p;
  assign onem_c = OMW'((one_m + HALF24) >> 24);
  assign prod   = plo + {p[31:0], 32'd0};
  assign pw_new = (prod + HALF24) >> 24;

  // quotient carries a rounding bit below its LSB
  assign q26   = div_q[RKW-1:0];
  assign mag   = RKW'(q26[RKW-1:1]) + RKW'(q26[0]);
  assign mag_c = (mag > Q24_ONE) ? Q24_ONE : mag;

  assign c_rdata = c_rsel ? c1_rdata : c0_rdata;
  assign rk_w    = {{(CVW - RKW){rk[RKW-1]}}, rk};

  // error and coefficient update: src - round(rk * x)
  always_comb begin
    unique case (state)
      S_EU_M1: src = fv;
      S_EU_M2: src = bn;
      default: src = $signed(c_rdata);
    endcase
    upd = sat32({{32{src[CVW-1]}}, src} - rs24(p));
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:   if (in_acc) state_next = S_SQR;
      S_SQR:    state_next = S_ENA;
      S_ENA:    state_next = last_r ? S_START : S_LOAD;
      S_START: begin
        if (n_le_m || energy == '0) state_next = S_OUT_RD;
        else                        state_next = S_PDIV;
      end
      S_PDIV:   if (cnt == 6'(PDIV_STEPS - 1)) state_next = S_PFIN;
      S_PFIN:   state_next = S_CP_RD;
      S_CP_RD:  state_next = S_CP_WR;
      S_CP_WR:  state_next = cp_more ? S_CP_RD : S_STG;
      S_STG:    state_next = S_CR_RD;
      S_CR_RD:  state_next = S_CR_M0;
      S_CR_M0:  state_next = S_CR_M1;
      S_CR_M1:  state_next = S_CR_M2;
      S_CR_M2:  state_next = S_CR_M3;
      S_CR_M3:  state_next = cr_more ? S_CR_RD : S_REFL;
      S_REFL: begin
        if (den <= 0 || big_k) state_next = S_PWR0;
        else                   state_next = S_RDIV;
      end
      S_RDIV:   if (cnt == 6'(RDIV_STEPS - 1)) state_next = S_RFIN;
      S_RFIN:   state_next = S_PWR0;
      S_PWR0:   state_next = S_PWR1;
      S_PWR1:   state_next = S_PWR2;
      S_PWR2:   state_next = S_PWR3;
      S_PWR3:   state_next = (k > KW'(1)) ? S_CU_RA : S_NEXT;
      S_CU_RA:  state_next = S_CU_RB;
      S_CU_RB:  state_next = S_CU_WR;
      S_CU_WR:  state_next = cu_more ? S_CU_RA : S_NEXT;
      S_NEXT:   state_next = (k == m) ? S_OUT_RD : S_EU_R0;
      S_EU_R0:  state_next = S_EU_L0;
      S_EU_L0:  state_next = S_EU_RD;
      S_EU_RD:  state_next = S_EU_M0;
      S_EU_M0:  state_next = S_EU_M1;
      S_EU_M1:  state_next = S_EU_M2;
      S_EU_M2:  state_next = eu_more ? S_EU_RD : S_STG;
      S_OUT_RD: state_next = S_OUT_LD;
      S_OUT_LD: state_next = S_OUT_WT;
      S_OUT_WT: begin
        if (out_acc) state_next = (i == m) ? S_LOAD : S_OUT_RD;
      end
      default:  state_next = S_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- unit controls
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_ctl = '0;
    div_dvd = '0;
    div_rem = '0;
    div_dsr = '0;
    f_we    = 1'b0;
    f_waddr = j[AW-1:0];
    f_wdata = upd;
    f_raddr = j[AW-1:0];
    b_we    = 1'b0;
    b_waddr = j[AW-1:0];
    b_wdata = upd;
    b_raddr = j[AW-1:0];
    c_we    = 1'b0;
    c_waddr = CAW'(i - KW'(1));
    c_wdata = upd;
    c_raddr = CAW'(i - KW'(1));
    c_rsel  = sel;
    unique case (state)
      S_LOAD: begin
        // store the sample as Q.8 while there is room
        f_we    = in_acc && !full;
        f_waddr = count[AW-1:0];
        f_wdata = {{(CVW - SW - 8){in_ch.sample[SW-1]}}, in_ch.sample, 8'd0};
      end
      S_SQR: begin
        mul_a = MOPW'(sample_r);
        mul_b = MOPW'(sample_r);
      end
      S_START: begin
        div_ctl.load = 1'b1;
        div_dvd      = DVW'({energy, 8'd0}) + DVW'(count >> 1);
        div_dsr      = 64'(count);
      end
      S_PDIV, S_RDIV: div_ctl.step = 1'b1;
      S_CP_RD:  f_raddr = jp1[AW-1:0];
      S_CP_WR: begin
        b_we    = 1'b1;
        b_wdata = f_rdata;
      end
      S_CR_M0: begin
        mul_a = MOPW'($signed(f_rdata));
        mul_b = MOPW'($signed(b_rdata));
      end
      S_CR_M1: begin
        mul_a = MOPW'(fv);
        mul_b = MOPW'(fv);
      end
      S_CR_M2: begin
        mul_a = MOPW'(bv);
        mul_b = MOPW'(bv);
      end
      S_REFL: begin
        div_ctl.load = 1'b1;
        div_rem      = a_abs;
        div_dsr      = den;
      end
      S_PWR0: begin
        mul_a = MOPW'(rk);
        mul_b = MOPW'(rk);
      end
      S_PWR1: begin
        mul_a = MOPW'({1'b0, power[31:0]});
        mul_b = MOPW'({1'b0, onem_c});
      end
      S_PWR2: begin
        mul_a = MOPW'({1'b0, power[63:32]});
        mul_b = MOPW'({1'b0, onem});
      end
      S_PWR3: begin
        // the new reflection coefficient lands at index k
        c_we    = 1'b1;
        c_waddr = CAW'(k - KW'(1));
        c_wdata = rk_w;
      end
      S_CU_RA:  c_raddr = CAW'(k - i - KW'(1));
      S_CU_RB: begin
        mul_a = MOPW'(rk);
        mul_b = MOPW'($signed(c_rdata));
      end
      S_CU_WR:  c_we = 1'b1;
      S_EU_R0: begin
        f_raddr = '0;
        b_raddr = '0;
      end
      S_EU_RD: begin
        f_raddr = jp1[AW-1:0];
        b_raddr = jp1[AW-1:0];
      end
      S_EU_M0: begin
        mul_a = MOPW'(rk);
        mul_b = MOPW'(bv);
      end
      S_EU_M1: begin
        f_we  = 1'b1;
        mul_a = MOPW'(rk);
        mul_b = MOPW'(fn);
      end
      S_EU_M2:  b_we = 1'b1;
      S_OUT_RD, S_OUT_LD: c_rsel = ~sel;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      order  <= 6'd16;
      count  <= '0;
      energy <= '0;
      sel    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_ch.valid && cfg_ch.ready) begin
        order <= cfg_ch.order;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            sample_r <= in_ch.sample;
            last_r   <= in_ch.last_sample;
            stored   <= !full;
            if (!full) count <= count + CW'(1);
          end
        end
        S_ENA: begin
          if (stored) energy <= energy + p[EW-1:0];
        end
        S_START: begin
          m   <= m_c;
          k   <= KW'(1);
          i   <= KW'(1);
          j   <= '0;
          cnt <= '0;
          power <= '0;
          if (n_le_m)               status <= ST_FEW;
          else if (energy == '0)    status <= ST_ZERO;
          else                      status <= ST_OK;
        end
        S_PDIV, S_RDIV: cnt <= cnt + 6'd1;
        S_PFIN:   power <= div_q;
        S_CP_WR:  j <= jp1;
        S_STG: begin
          num <= '0;
          den <= '0;
          j   <= '0;
        end
        S_CR_M0: begin
          fv <= $signed(f_rdata);
          bv <= $signed(b_rdata);
        end
        S_CR_M1:  num <= sat_add61(num, p);
        S_CR_M2:  den <= sat_add61(den, p);
        S_CR_M3: begin
          den <= sat_add61(den, p);
          j   <= jp1;
        end
        S_REFL: begin
          cnt <= '0;
          if (den <= 0)      rk <= '0;
          else if (num[63])  rk <= -$signed(Q24_ONE);
          else               rk <= $signed(Q24_ONE);
        end
        S_RFIN:   rk <= num[63] ? -$signed(mag_c) : $signed(mag_c);
        S_PWR1:   onem <= onem_c;
        S_PWR2:   plo <= p[63:0];
        S_PWR3: begin
          power <= pw_new;
          i     <= KW'(1);
        end
        S_CU_WR:  i <= ip1;
        S_NEXT: begin
          i <= KW'(1);
          j <= '0;
          // hand the new coefficients over as the previous set
          if (k != m) sel <= ~sel;
        end
        S_EU_L0: begin
          fv <= $signed(f_rdata);
          bv <= $signed(b_rdata);
        end
        S_EU_M0: begin
          fn <= $signed(f_rdata);
          bn <= $signed(b_rdata);
        end
        S_EU_M2: begin
          fv <= fn;
          bv <= bn;
          j  <= jp1;
          if (!eu_more) k <= k + KW'(1);
        end
        S_OUT_LD: begin
          o_index  <= 6'(i);
          o_value  <= (status == ST_OK) ? $signed(c_rdata) : '0;
          o_power  <= power[PWW-1:0];
          o_status <= status;
          o_last   <= (i == m);
        end
        S_OUT_WT: begin
          if (out_acc) begin
            i <= ip1;
            // record done: start the next one empty
            if (i == m) begin
              count  <= '0;
              energy <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- instances
  blc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  blc_div u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .dvd_in (div_dvd),
    .rem_in (div_rem),
    .dsr_in (div_dsr),
    .q      (div_q)
  );

  blc_ram #(.WIDTH(CVW), .DEPTH(MAX_SAMPLES)) u_fwd (
    .clk (clk), .we (f_we), .waddr (f_waddr), .wdata (f_wdata),
    .raddr (f_raddr), .rdata (f_rdata)
  );

  blc_ram #(.WIDTH(CVW), .DEPTH(MAX_SAMPLES)) u_bwd (
    .clk (clk), .we (b_we), .waddr (b_waddr), .wdata (b_wdata),
    .raddr (b_raddr), .rdata (b_rdata)
  );

  // coefficient banks: one holds the previous stage, the other takes the new one
  blc_ram #(.WIDTH(CVW), .DEPTH(MAX_ORDER)) u_coef0 (
    .clk (clk), .we (c_we && sel), .waddr (c_waddr), .wdata (c_wdata),
    .raddr (c_raddr), .rdata (c0_rdata)
  );

  blc_ram #(.WIDTH(CVW), .DEPTH(MAX_ORDER)) u_coef1 (
    .clk (clk), .we (c_we && !sel), .waddr (c_waddr), .wdata (c_wdata),
    .raddr (c_raddr), .rdata (c1_rdata)
  );

endmodule

// ===== rtl/core/blc_ram.sv =====
module blc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/blc_mul.sv =====
module blc_mul (
  input  logic                             clk,
  input  logic signed [blc_pkg::MOPW-1:0]  a,
  input  logic signed [blc_pkg::MOPW-1:0]  b,
  output logic signed [63:0]               p
);
  import blc_pkg::*;

  logic signed [2*MOPW-1:0] full;

  assign full = a * b;

  // register every product before it is used
  always_ff @(posedge clk) begin
    p <= full[63:0];
  end
endmodule

// ===== rtl/core/blc_div.sv =====
module blc_div (
  input  logic                        clk,
  input  blc_pkg::div_ctl_t           ctl,
  input  logic [blc_pkg::DVW-1:0]     dvd_in,
  input  logic [63:0]                 rem_in,
  input  logic [63:0]                 dsr_in,
  output logic [63:0]                 q
);
  import blc_pkg::*;

  logic [63:0]    r;
  logic [63:0]    d;
  logic [DVW-1:0] dvd;
  logic [63:0]    rs;
  logic           ge;

  // restoring division, one quotient bit per step
  assign rs = {r[62:0], dvd[DVW-1]};
  assign ge = rs >= d;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r   <= rem_in;
      d   <= dsr_in;
      dvd <= dvd_in;
      q   <= '0;
    end else if (ctl.step) begin
      r   <= ge ? rs - d : rs;
      q   <= {q[62:0], ge};
      dvd <= {dvd[DVW-2:0], 1'b0};
    end
  end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Burg coefficient scoreboard: keeps its own copy of the sample buffer, the
// order register and the recursion, and queues the expected coefficient items
// for each record that an item flagged last closes.
class burg_scoreboard;
  localparam int NBUF = 1024;
  localparam int NORD = 32;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] coef;
    logic [39:0]        pwr;
    logic [1:0]         st;
    logic               fin;
  } coef_item_t;

  coef_item_t        coef_q[$];
  logic [5:0]        order_reg = 6'd16;
  int                fwd[NBUF];
  int                bwd[NBUF];
  int                prev_a[NORD+1];
  int                cur_a[NORD+1];
  int unsigned       count = 0;
  longint unsigned   energy = 0;
  int                mismatches = 0;
  bit                failed = 0;

  function automatic longint clamp_acc(longint s);
    longint lim;
    lim = 64'sd1 << 61;
    if (s > lim) return lim;
    if (s < -lim) return -lim;
    return s;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint round24(longint v);
    if (v >= 0) return (v + (64'sd1 << 23)) >>> 24;
    return -((-v + (64'sd1 << 23)) >>> 24);
  endfunction

  // k = 2*num/den in Q.24, rounded, clamped to +-1
  function automatic int reflection(longint num, longint den);
    longint unsigned a, d, r, q;
    q = 0;
    if (den <= 0) return 0;
    a = (num < 0) ? -num : num;
    d = den;
    if (2 * a >= d) begin
      q = 64'd1 << 24;
    end else begin
      r = a;
      for (int i = 0; i < 25; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      r = r << 1;
      if (r >= d) q++;
      if (q > (64'd1 << 24)) q = 64'd1 << 24;
    end
    return (num < 0) ? -int'(q) : int'(q);
  endfunction

  function void set_order(logic [5:0] v);
    order_reg = v;
  endfunction

  function int pending();
    return coef_q.size();
  endfunction

  // solve one record and queue its coefficient items
  function void solve_record();
    int unsigned     n, m;
    logic [1:0]      st;
    longint unsigned pw, onem;
    longint          num, den, rk, f, b;
    coef_item_t      it;
    n = count;
    m = order_reg;
    st = 2'd0;
    pw = 0;
    if (m < 1) m = 1;
    if (m > NORD) m = NORD;
    for (int i = 0; i <= NORD; i++) cur_a[i] = 0;
    if (n <= m) begin
      st = 2'd1;
    end else if (energy == 0) begin
      st = 2'd2;
    end else begin
      pw = (energy * 256 + n / 2) / n;
      for (int j = 0; j + 1 < n; j++) bwd[j] = fwd[j+1];
      for (int k = 1; k <= m; k++) begin
        num = 0;
        den = 0;
        for (int j = 0; j < n - k; j++) begin
          f = fwd[j];
          b = bwd[j];
          num = clamp_acc(num + f * b);
          den = clamp_acc(den + f * f);
          den = clamp_acc(den + b * b);
        end
        rk = reflection(num, den);
        cur_a[k] = int'(rk);
        onem = ((64'sd1 << 48) - rk * rk + (64'sd1 << 23)) >>> 24;
        pw = (pw * onem + (64'd1 << 23)) >> 24;
        for (int i = 1; i < k; i++)
          cur_a[i] = clamp32(longint'(prev_a[i]) - round24(rk * prev_a[k-i]));
        if (k == m) break;
        for (int i = 1; i <= k; i++) prev_a[i] = cur_a[i];
        for (int j = 0; j + 1 < n - k; j++) begin
          fwd[j] = clamp32(longint'(fwd[j]) - round24(rk * bwd[j]));
          bwd[j] = clamp32(longint'(bwd[j+1]) - round24(rk * fwd[j+1]));
        end
      end
    end
    for (int k = 1; k <= m; k++) begin
      it.idx  = k[5:0];
      it.coef = (st == 2'd0) ? cur_a[k] : 0;
      it.pwr  = pw[39:0];
      it.st   = st;
      it.fin  = (k == m);
      coef_q.push_back(it);
    end
    count = 0;
    energy = 0;
  endfunction

  function void note_sample(logic signed [15:0] s, logic last);
    longint sq;
    if (count < NBUF) begin
      fwd[count] = int'(s) * 256;
      count++;
      sq = longint'(s) * s;
      energy = (energy + sq) & 48'hffffffffffff;
    end
    if (last) solve_record();
  endfunction

  function void check_coef(logic [5:0] idx, logic signed [31:0] coef, logic [39:0] pwr,
                           logic [1:0] st, logic fin);
    coef_item_t e;
    if (coef_q.size() == 0) begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10) $display("unexpected coefficient item idx=%0d", idx);
      return;
    end
    e = coef_q.pop_front();
    if (e.idx !== idx || e.coef !== coef || e.pwr !== pwr || e.st !== st || e.fin !== fin)
    begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp idx=%0d coef=%0d pwr=%0d st=%0d last=%0b",
                  " | got idx=%0d coef=%0d pwr=%0d st=%0d last=%0b"},
                 e.idx, e.coef, e.pwr, e.st, e.fin, idx, coef, pwr, st, fin);
    end
  endfunction
endclass

module tb_top;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 200;

  logic clk;
  logic rst;

  blc_in_if  in_if ();
  blc_out_if out_if ();
  blc_cfg_if cfg_if ();

  burg_lpc_coefficients_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  burg_scoreboard sb = new();

  // idle percentages for sender and receiver, changed by phase
  int snd_idle = 34;
  int rcv_idle = 79;
  int quiet    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: drop ready at random per the current phase
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else     out_if.ready <= ($urandom_range(99) >= rcv_idle);
  end

  // check every accepted coefficient item
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready)
      sb.check_coef(out_if.coef_index, out_if.coef_value, out_if.error_power,
                    out_if.status, out_if.last_result);
  end

  // watchdog: count cycles in which no handshake completes on any channel
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // drive one sample item, with an optional idle gap ahead of it
  task automatic send_sample(logic signed [15:0] s, logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    in_if.last_sample <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(s, last);
  endtask

  // hold the sender until every expected item has come, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // write the order register; the block must be idle
  task automatic write_order(logic [5:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.order <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_order(v);
  endtask

  // one record: shape 0 full random, 1 small values, 2 resonant, 3 sparse, 4 all zero
  task automatic send_record(int n, int shape);
    logic signed [15:0] s;
    int y1, y2, y;
    y1 = 0;
    y2 = 0;
    for (int i = 0; i < n; i++) begin
      case (shape)
        0: begin
          s = 16'($urandom());
        end
        1: begin
          s = $signed(16'($urandom_range(64))) - 16'sd32;
        end
        2: begin
          // second-order resonance plus noise
          y = (y1 * 3) / 2 - (y2 * 9) / 10 + int'($urandom_range(2000)) - 1000;
          if (y > 32767) y = 32767;
          if (y < -32768) y = -32768;
          y2 = y1;
          y1 = y;
          s = 16'(y);
        end
        3: begin
          s = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'sd0;
        end
        default: begin
          s = 16'sd0;
        end
      endcase
      send_sample(s, i == n - 1);
    end
  endtask

  initial begin
    int n;
    int ord;
    int shape;
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.last_sample = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.order = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset order 16 with a short record gives too few samples
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    for (int i = 0; i < 7; i++) send_sample(16'($urandom()), 1'b0);
    send_sample(16'sh0001, 1'b1);
    write_order(6'd1);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b1);
    // zero energy record
    send_record(3, 4);
    // single sample record, too few for order 1
    send_sample(16'sh1234, 1'b1);
    write_order(6'd0);
    send_record(3, 0);
    write_order(6'd63);
    send_record(5, 0);

    // random records through three idle phases
    for (int r = 0; r < 13; r++) begin
      if (r == 5) begin
        snd_idle = 79;
        rcv_idle = 34;
      end else if (r == 9) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (r)
        0:       ord = 32;
        1:       ord = 1;
        2:       ord = 2;
        default: ord = $urandom_range(63);
      endcase
      if (r == 7) ord = 2;
      write_order(ord[5:0]);
      shape = $urandom_range(3);
      if (r == 0) begin
        send_record(48, 2);
      end else begin
        n = $urandom_range(56, 2);
        send_record(n, shape);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!sb.failed && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
